>>> hdl/tre_pkg.sv
// ----------------------------------------------------------------------------
// Text row expander package
// Field widths, input kinds, register indexes, character constants and
// the hex digit function shared by the channel interfaces and the expander.
// ----------------------------------------------------------------------------
package tre_pkg;

   localparam int KIND_W   = 2;
   localparam int CHAR_W   = 21;
   localparam int OFFSET_W = 16;
   localparam int COL_W    = 10;
   localparam int TAB_W    = 4;
   localparam int ADDR_W   = 3;
   localparam int DATA_W   = 32;

   localparam logic [KIND_W-1:0] KIND_START = 2'd0;
   localparam logic [KIND_W-1:0] KIND_CHAR  = 2'd1;
   localparam logic [KIND_W-1:0] KIND_END   = 2'd2;

   localparam logic REG_SCREEN_COLS = 1'b0;
   localparam logic REG_TAB_MASK    = 1'b1;

   localparam logic [COL_W-1:0] SCREEN_COLS_RESET = 10'd80;
   localparam logic [TAB_W-1:0] TAB_MASK_RESET    = 4'd7;

   localparam logic [CHAR_W-1:0] CH_TAB       = 21'h09;
   localparam logic [CHAR_W-1:0] CH_SPACE     = 21'h20;
   localparam logic [CHAR_W-1:0] CH_CTRL_FLIP = 21'h40;
   localparam logic [CHAR_W-1:0] CH_DEL       = 21'h7f;
   localparam logic [CHAR_W-1:0] CH_HEX_LO    = 21'h80;
   localparam logic [CHAR_W-1:0] CH_HEX_HI    = 21'hA0;
   localparam logic [CHAR_W-1:0] CH_CARET     = 21'h5e;
   localparam logic [CHAR_W-1:0] CH_QUESTION  = 21'h3f;
   localparam logic [CHAR_W-1:0] CH_BACKSLASH = 21'h5c;
   localparam logic [CHAR_W-1:0] CH_DOLLAR    = 21'h24;
   localparam logic [CHAR_W-1:0] CH_NONE      = 21'h00;
   localparam logic [CHAR_W-1:0] CH_DIGIT0    = 21'h30;
   localparam logic [CHAR_W-1:0] CH_LETTER_A  = 21'h57;

   typedef struct packed {
      logic [CHAR_W-1:0] cell_char;
      logic [COL_W-1:0]  screen_column;
      logic              erase_rest;
   } res_type;

   function automatic logic [CHAR_W-1:0] hex_digit(input logic [3:0] d);
      logic [CHAR_W-1:0] d_ext;
      d_ext = {{(CHAR_W-4){1'b0}}, d};
      if (d < 4'd10) begin
         return CH_DIGIT0 + d_ext;
      end
      return CH_LETTER_A + d_ext;
   endfunction

endpackage

>>> hdl/tre_req_if.sv
// ----------------------------------------------------------------------------
// Text row expander input channel
// Valid/ready channel carrying one input item: kind, code point, offset.
// ----------------------------------------------------------------------------
interface tre_req_if import tre_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [KIND_W-1:0]   kind;
   logic [CHAR_W-1:0]   code_point;
   logic [OFFSET_W-1:0] row_offset;

   modport source (output valid, kind, code_point, row_offset, input ready);
   modport sink   (input valid, kind, code_point, row_offset, output ready);
endinterface

>>> hdl/tre_rsp_if.sv
// ----------------------------------------------------------------------------
// Text row expander result channel
// Valid/ready channel carrying one result item: a terminal cell or erase.
// ----------------------------------------------------------------------------
interface tre_rsp_if import tre_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [CHAR_W-1:0] cell_char;
   logic [COL_W-1:0]  screen_column;
   logic              erase_rest;
   logic              last;

   modport source (output valid, cell_char, screen_column, erase_rest, last,
                   input ready);
   modport sink   (input valid, cell_char, screen_column, erase_rest, last,
                   output ready);
endinterface

>>> hdl/text_row_column_expander.sv
// ----------------------------------------------------------------------------
// Text row column expander
// Expands the characters of one text row into terminal cells, with tab
// stops, caret and hex escapes, clipping to a window and end-of-row markers.
//
// The req channel takes start-of-row, character and end-of-row items. The
// rsp channel returns the cells of each item, last marking the final one.
// Registers screen_cols (address 0) and tab_mask (address 4) are written
// over the APB port; the user must write them only while the block is
// idle, which the block itself does not enforce; pready is always high.
// A small sequencer steps through the cells of an item, one cell a cycle
// unless stalled, through a single window compare and column increment
// unit. A character item takes one step per cell it expands to, shown or
// dropped (one to sixteen), and an end-of-row item always takes three
// steps. The input is not ready while an item runs: the item is accepted
// in the idle state, steps in the run state, then hands any final result
// to the output register in the flush state. A start-of-row item is taken
// in the idle state alone. Each result waits in a hold register until the
// next one is known, so that last can be set.
// A stalled receiver stops the sequencer once both the hold and output
// registers are full; nothing is lost. Reset restores screen_cols to 80,
// tab_mask to 7 and clears the row state and both registers.
// ----------------------------------------------------------------------------
module text_row_column_expander import tre_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   tre_req_if.sink           req_ch,
   tre_rsp_if.source         rsp_ch,
   input  logic              psel,
   input  logic              penable,
   input  logic              pwrite,
   input  logic [ADDR_W-1:0] paddr,
   input  logic [DATA_W-1:0] pwdata,
   output logic [DATA_W-1:0] prdata,
   output logic              pready
);

   typedef enum logic [1:0] {ST_IDLE, ST_RUN, ST_FLUSH} state_type;
   typedef enum logic [2:0] {CLS_PLAIN, CLS_TAB, CLS_CTRL, CLS_DEL, CLS_HEX}
      cls_type;

   state_type           state_ff, state_in;
   cls_type             cls_ff, cls_in;
   logic                end_mode_ff, end_mode_in;
   logic [CHAR_W-1:0]   cp_ff, cp_in;
   logic [3:0]          idx_ff, idx_in;
   logic [3:0]          last_idx_ff, last_idx_in;
   logic [COL_W-1:0]    screen_cols_ff, screen_cols_in;
   logic [TAB_W-1:0]    tab_mask_ff, tab_mask_in;
   logic [OFFSET_W-1:0] line_column_ff, line_column_in;
   logic [OFFSET_W-1:0] window_offset_ff, window_offset_in;
   logic [COL_W-1:0]    cells_painted_ff, cells_painted_in;
   logic                overflowed_ff, overflowed_in;
   logic                pend_valid_ff, pend_valid_in;
   res_type             pend_ff, pend_in;
   logic                out_valid_ff, out_valid_in;
   res_type             out_ff, out_in;
   logic                out_last_ff, out_last_in;

   logic              cfg_write;
   logic              out_free;
   logic              step_prod;
   logic              blocked;
   res_type           step_res;
   logic [CHAR_W-1:0] step_char;
   logic [OFFSET_W:0] right_edge;
   logic              in_left;
   logic              cell_ovf;

   assign cfg_write = psel && penable && pwrite;
   assign pready    = 1'b1;
   assign out_free  = !out_valid_ff || rsp_ch.ready;

   always_comb begin
      case (paddr[2])
         REG_SCREEN_COLS: prdata = {{(DATA_W-COL_W){1'b0}}, screen_cols_ff};
         default:         prdata = {{(DATA_W-TAB_W){1'b0}}, tab_mask_ff};
      endcase
   end

   always_comb begin
      case (cls_ff)
         CLS_TAB:  step_char = CH_SPACE;
         CLS_CTRL: step_char = (idx_ff == 4'd0) ? CH_CARET : (cp_ff ^ CH_CTRL_FLIP);
         CLS_DEL:  step_char = (idx_ff == 4'd0) ? CH_CARET : CH_QUESTION;
         CLS_HEX: begin
            if (idx_ff == 4'd0) begin
               step_char = CH_BACKSLASH;
            end else if (idx_ff == 4'd1) begin
               step_char = hex_digit(cp_ff[7:4]);
            end else begin
               step_char = hex_digit(cp_ff[3:0]);
            end
         end
         default:  step_char = cp_ff;
      endcase
   end

   assign right_edge = {1'b0, window_offset_ff}
                     + {{(OFFSET_W+1-COL_W){1'b0}}, screen_cols_ff};
   assign in_left    = line_column_ff >= window_offset_ff;
   assign cell_ovf   = ({1'b0, line_column_ff} >= right_edge)
                     || (in_left && (cells_painted_ff >= screen_cols_ff));

   always_comb begin
      step_prod = 1'b0;
      step_res  = '{cell_char: CH_NONE, screen_column: '0, erase_rest: 1'b0};
      if (end_mode_ff) begin
         case (idx_ff)
            4'd0: begin
               step_prod = 1'b1;
               step_res  = '{cell_char: CH_NONE, screen_column: cells_painted_ff,
                             erase_rest: 1'b1};
            end
            4'd1: begin
               step_prod = overflowed_ff;
               step_res  = '{cell_char: CH_DOLLAR,
                             screen_column: (screen_cols_ff == '0) ? '0
                                          : screen_cols_ff - 10'd1,
                             erase_rest: 1'b0};
            end
            default: begin
               step_prod = window_offset_ff != '0;
               step_res  = '{cell_char: CH_DOLLAR, screen_column: '0,
                             erase_rest: 1'b0};
            end
         endcase
      end else begin
         step_prod = !cell_ovf && in_left;
         step_res  = '{cell_char: step_char, screen_column: cells_painted_ff,
                       erase_rest: 1'b0};
      end
   end

   assign blocked = step_prod && pend_valid_ff && !out_free;

   always_comb begin
      state_in         = state_ff;
      cls_in           = cls_ff;
      end_mode_in      = end_mode_ff;
      cp_in            = cp_ff;
      idx_in           = idx_ff;
      last_idx_in      = last_idx_ff;
      screen_cols_in   = screen_cols_ff;
      tab_mask_in      = tab_mask_ff;
      line_column_in   = line_column_ff;
      window_offset_in = window_offset_ff;
      cells_painted_in = cells_painted_ff;
      overflowed_in    = overflowed_ff;
      pend_valid_in    = pend_valid_ff;
      pend_in          = pend_ff;
      out_valid_in     = out_valid_ff && !rsp_ch.ready;
      out_in           = out_ff;
      out_last_in      = out_last_ff;

      if (cfg_write) begin
         case (paddr[2])
            REG_SCREEN_COLS: screen_cols_in = pwdata[COL_W-1:0];
            default:         tab_mask_in    = pwdata[TAB_W-1:0];
         endcase
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_ch.valid) begin
               case (req_ch.kind)
                  KIND_START: begin
                     window_offset_in = req_ch.row_offset;
                     line_column_in   = '0;
                     cells_painted_in = '0;
                     overflowed_in    = 1'b0;
                  end
                  KIND_CHAR: begin
                     state_in    = ST_RUN;
                     end_mode_in = 1'b0;
                     idx_in      = '0;
                     cp_in       = req_ch.code_point;
                     if (req_ch.code_point == CH_TAB) begin
                        cls_in      = CLS_TAB;
                        last_idx_in = tab_mask_ff - (line_column_ff[3:0] & tab_mask_ff);
                     end else if (req_ch.code_point < CH_SPACE) begin
                        cls_in      = CLS_CTRL;
                        last_idx_in = 4'd1;
                     end else if (req_ch.code_point == CH_DEL) begin
                        cls_in      = CLS_DEL;
                        last_idx_in = 4'd1;
                     end else if (req_ch.code_point >= CH_HEX_LO
                                  && req_ch.code_point <= CH_HEX_HI) begin
                        cls_in      = CLS_HEX;
                        last_idx_in = 4'd2;
                     end else begin
                        cls_in      = CLS_PLAIN;
                        last_idx_in = 4'd0;
                     end
                  end
                  KIND_END: begin
                     state_in    = ST_RUN;
                     end_mode_in = 1'b1;
                     idx_in      = '0;
                     last_idx_in = 4'd2;
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_RUN: begin
            if (!blocked) begin
               if (!end_mode_ff) begin
                  if (cell_ovf) begin
                     overflowed_in = 1'b1;
                  end else if (in_left) begin
                     cells_painted_in = cells_painted_ff + 10'd1;
                  end
                  if (line_column_ff != '1) begin
                     line_column_in = line_column_ff + 16'd1;
                  end
               end
               if (step_prod) begin
                  pend_valid_in = 1'b1;
                  pend_in       = step_res;
                  if (pend_valid_ff) begin
                     out_valid_in = 1'b1;
                     out_in       = pend_ff;
                     out_last_in  = 1'b0;
                  end
               end
               if (idx_ff == last_idx_ff) begin
                  state_in = ST_FLUSH;
               end else begin
                  idx_in = idx_ff + 4'd1;
               end
            end
         end
         ST_FLUSH: begin
            if (!pend_valid_ff) begin
               state_in = ST_IDLE;
            end else if (out_free) begin
               out_valid_in  = 1'b1;
               out_in        = pend_ff;
               out_last_in   = 1'b1;
               pend_valid_in = 1'b0;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= ST_IDLE;
         screen_cols_ff   <= SCREEN_COLS_RESET;
         tab_mask_ff      <= TAB_MASK_RESET;
         line_column_ff   <= '0;
         window_offset_ff <= '0;
         cells_painted_ff <= '0;
         overflowed_ff    <= 1'b0;
         pend_valid_ff    <= 1'b0;
         out_valid_ff     <= 1'b0;
      end else begin
         state_ff         <= state_in;
         screen_cols_ff   <= screen_cols_in;
         tab_mask_ff      <= tab_mask_in;
         line_column_ff   <= line_column_in;
         window_offset_ff <= window_offset_in;
         cells_painted_ff <= cells_painted_in;
         overflowed_ff    <= overflowed_in;
         pend_valid_ff    <= pend_valid_in;
         out_valid_ff     <= out_valid_in;
      end
      cls_ff      <= cls_in;
      end_mode_ff <= end_mode_in;
      cp_ff       <= cp_in;
      idx_ff      <= idx_in;
      last_idx_ff <= last_idx_in;
      pend_ff     <= pend_in;
      out_ff      <= out_in;
      out_last_ff <= out_last_in;
   end

   assign req_ch.ready         = state_ff == ST_IDLE;
   assign rsp_ch.valid         = out_valid_ff;
   assign rsp_ch.cell_char     = out_ff.cell_char;
   assign rsp_ch.screen_column = out_ff.screen_column;
   assign rsp_ch.erase_rest    = out_ff.erase_rest;
   assign rsp_ch.last          = out_last_ff;

   a_idle_no_pending: assert property (@(posedge clock) disable iff (reset)
      req_ch.ready |-> !pend_valid_ff)
      else $error("held result left behind when accepting a new item");

   a_stall_holds_column: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_RUN) && blocked |=> $stable(line_column_ff)
                                          && $stable(cells_painted_ff))
      else $error("row state advanced while the sequencer was stalled");

   a_flush_from_run: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FLUSH) |-> ($past(state_ff) == ST_RUN)
                                 || ($past(state_ff) == ST_FLUSH))
      else $error("flush entered without running the item");

endmodule
